/* rtl/pzxod_pkg.sv */
// shared types, constants and table generators for the proximity zx position and orb detector
`default_nettype none

package pzxod_pkg;

   // port geometry
   localparam int REQ_W       = 48;
   localparam int RSP_W       = 88;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 16;

   // result word bit places
   localparam int RSP_VALID_BIT = 49;
   localparam int RSP_HIT_BIT   = 82;

   // defaults for top-level parameters
   localparam int ORB_LIMIT_DEFAULT  = 4;
   localparam int DIST_DEPTH_DEFAULT = 256;

   // shared multiplier
   localparam int MUL_W  = 30;
   localparam int PROD_W = 2 * MUL_W;

   // distance tables
   localparam int TBL_W = 17;
   localparam int OCT_W = 27;
   localparam int OCT_N = 17;

   localparam logic [63:0] POW_K_Q32 = 64'd2583422829;
   localparam logic [63:0] ONE_Q32   = 64'h0000_0001_0000_0000;
   localparam logic [63:0] DIST_GAIN = 64'd1200;

   localparam logic [16:0] DIST_OFFSET = 17'd60;
   localparam logic [MUL_W-1:0] X_GAIN     = MUL_W'(50);
   localparam logic [MUL_W-1:0] Z_GAIN     = MUL_W'(2560000);
   // floor(2^38 / 1250), used for the divide by 1250 after a 20-bit shift
   localparam logic [MUL_W-1:0] RECIP_1250 = MUL_W'(219902325);
   localparam logic [29:0]      Z_DIVISOR  = 30'd1250;

   // orb limits, entering and leaving
   localparam logic signed [15:0] ORB_CX_ENTER  = 16'sd80;
   localparam logic signed [15:0] ORB_CX_LEAVE  = 16'sd95;
   localparam logic signed [15:0] ORB_CZHI_ENTER = 16'sd850;
   localparam logic signed [15:0] ORB_CZHI_LEAVE = 16'sd870;
   localparam logic signed [15:0] ORB_CZLO_ENTER = 16'sd200;
   localparam logic signed [15:0] ORB_CZLO_LEAVE = 16'sd180;
   localparam logic signed [15:0] ORB_SX_ENTER  = 16'sd440;
   localparam logic signed [15:0] ORB_SX_LEAVE  = 16'sd480;
   localparam logic signed [15:0] ORB_SZHI_ENTER = 16'sd750;
   localparam logic signed [15:0] ORB_SZHI_LEAVE = 16'sd770;
   localparam logic signed [15:0] ORB_SZLO_ENTER = 16'sd170;
   localparam logic signed [15:0] ORB_SZLO_LEAVE = 16'sd160;
   localparam logic [15:0]        ORB_CMAX_ENTER = 16'd2500;
   localparam logic [15:0]        ORB_CMAX_LEAVE = 16'd2700;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MODE    = 3'd0,
      CSR_ACT_THR = 3'd1,
      CSR_POS_MIN = 3'd2,
      CSR_NOISE_L = 3'd3,
      CSR_NOISE_C = 3'd4,
      CSR_NOISE_R = 3'd5
   } csr_index_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_PREP,
      ST_LOOK,
      ST_WLO,
      ST_WHI,
      ST_GAIN,
      ST_SCALE,
      ST_DIST,
      ST_XMUL,
      ST_XSQ,
      ST_ZSUM,
      ST_ZNUM,
      ST_ZRCP,
      ST_ZFIN,
      ST_ORB,
      ST_DONE
   } state_type;

   function automatic logic [63:0] isqrt64(input logic [63:0] a_in);
      logic [63:0] a;
      logic [63:0] res;
      logic [63:0] bit_v;
      a     = a_in;
      res   = '0;
      bit_v = 64'h4000_0000_0000_0000;
      for (int k = 0; k < 32; k++) begin
         if (a >= res + bit_v) begin
            a   = a - (res + bit_v);
            res = (res >> 1) + bit_v;
         end else begin
            res = res >> 1;
         end
         bit_v = bit_v >> 2;
      end
      return res;
   endfunction

   // 2^-y, y and result in q.32
   function automatic logic [63:0] exp2_neg(input logic [63:0] y);
      logic [127:0] r;
      logic [63:0]  hr;
      logic [63:0]  n;
      n = y >> 32;
      if (n >= 64'd33) begin
         return '0;
      end
      r  = 128'(ONE_Q32);
      hr = isqrt64(64'h8000_0000_0000_0000);
      for (int j = 1; j <= 32; j++) begin
         if (y[32-j]) begin
            r = (r * 128'(hr)) >> 32;
         end
         hr = isqrt64(hr << 32);
      end
      return 64'(r >> n);
   endfunction

   // fractional log2 of a q1.31 mantissa, as q.32
   function automatic logic [63:0] log2_mant(input logic [63:0] m);
      logic [127:0] x;
      logic [63:0]  res;
      x   = 128'(m);
      res = '0;
      for (int k = 1; k <= 32; k++) begin
         x = (x * x) >> 31;
         if (x >= 128'(ONE_Q32)) begin
            x = x >> 1;
            res[32-k] = 1'b1;
         end
      end
      return res;
   endfunction

   // restoring long division, elaboration only
   function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
      logic [63:0] q;
      logic [64:0] r;
      q = '0;
      r = '0;
      for (int k = 63; k >= 0; k--) begin
         r = {r[63:0], num[k]};
         if (r >= 65'(den)) begin
            r    = r - 65'(den);
            q[k] = 1'b1;
         end
      end
      return q;
   endfunction

   function automatic logic [TBL_W-1:0] frac_entry(input int i, input int depth);
      logic [63:0]  m;
      logic [63:0]  y;
      logic [127:0] t;
      if (i < depth) begin
         m = udiv64((64'(depth) + 64'(i)) << 31, 64'(depth));
         t = 128'(POW_K_Q32) * 128'(log2_mant(m));
         y = 64'(t >> 32);
      end else begin
         y = POW_K_Q32;
      end
      return TBL_W'(exp2_neg(y) >> 16);
   endfunction

   function automatic logic [OCT_W-1:0] octave_entry(input int i);
      logic [127:0] t;
      t = 128'(DIST_GAIN) * 128'(exp2_neg(POW_K_Q32 * 64'(i)));
      return OCT_W'(t >> 16);
   endfunction

   function automatic logic orb_test(input logic signed [15:0] z,
                                     input logic signed [15:0] x,
                                     input logic [15:0] center,
                                     input logic leaving);
      logic signed [15:0] cx, czhi, czlo, sx, szhi, szlo;
      logic [15:0]        cmax;
      logic               in_c, in_s;
      cx   = leaving ? ORB_CX_LEAVE   : ORB_CX_ENTER;
      czhi = leaving ? ORB_CZHI_LEAVE : ORB_CZHI_ENTER;
      czlo = leaving ? ORB_CZLO_LEAVE : ORB_CZLO_ENTER;
      sx   = leaving ? ORB_SX_LEAVE   : ORB_SX_ENTER;
      szhi = leaving ? ORB_SZHI_LEAVE : ORB_SZHI_ENTER;
      szlo = leaving ? ORB_SZLO_LEAVE : ORB_SZLO_ENTER;
      cmax = leaving ? ORB_CMAX_LEAVE : ORB_CMAX_ENTER;
      in_c = (x < cx) && (x > -cx) && (z < czhi) && (z > czlo);
      in_s = (x < sx) && (x > -sx) && (z < szhi) && (z > szlo);
      return (center < cmax) && (in_c || in_s);
   endfunction

endpackage

`default_nettype wire

/* rtl/pzxod_mul.sv */
// shared signed multiplier with registered product
`default_nettype none

module pzxod_mul (
   input  wire logic                               clock,
   input  wire logic signed [pzxod_pkg::MUL_W-1:0]  op_a,
   input  wire logic signed [pzxod_pkg::MUL_W-1:0]  op_b,
   output logic signed [pzxod_pkg::PROD_W-1:0]      prod_ff
);
   import pzxod_pkg::*;

   always_ff @(posedge clock) begin
      prod_ff <= PROD_W'(op_a) * PROD_W'(op_b);
   end

endmodule

`default_nettype wire

/* rtl/pzxod_dist_rom.sv */
// distance shape table and octave scale table with registered read
`default_nettype none

module pzxod_dist_rom #(
   parameter int DEPTH = pzxod_pkg::DIST_DEPTH_DEFAULT
) (
   input  wire logic                            clock,
   input  wire logic                            en,
   input  wire logic [$clog2(DEPTH+1)-1:0]      idx,
   input  wire logic [4:0]                      expo,
   output logic [pzxod_pkg::TBL_W-1:0]          t_lo_ff,
   output logic [pzxod_pkg::TBL_W-1:0]          t_hi_ff,
   output logic [pzxod_pkg::OCT_W-1:0]          scale_ff
);
   import pzxod_pkg::*;

   localparam int IDX_W = $clog2(DEPTH + 1);

   logic [TBL_W-1:0] shape [0:DEPTH];
   logic [OCT_W-1:0] octave [0:OCT_N-1];

   for (genvar g = 0; g <= DEPTH; g++) begin : g_shape
      localparam logic [TBL_W-1:0] VAL = frac_entry(g, DEPTH);
      assign shape[g] = VAL;
   end

   for (genvar g = 0; g < OCT_N; g++) begin : g_octave
      localparam logic [OCT_W-1:0] VAL = octave_entry(g);
      assign octave[g] = VAL;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         t_lo_ff  <= shape[idx];
         t_hi_ff  <= shape[idx + IDX_W'(1)];
         scale_ff <= octave[expo];
      end
   end

endmodule

`default_nettype wire

/* rtl/proximity_zx_position_orb_detector_unit.sv */
// top level: proximity zx position and orb detector around one shared multiplier
// position off or out of range: the sequencer goes from idle straight to the done state
// position on: distance steps per side, then x and z, then the orb step if enabled
// one word at a time, taken only in idle; the pace is set by the shared multiplier,
//   which the sequencer walks through 7 steps per side and 6 steps for x and z
// reset: synchronous active high; clears sequencer, config, orb state and last x/z
`default_nettype none

module proximity_zx_position_orb_detector_unit #(
   parameter int ORB_COUNT_LIMIT  = pzxod_pkg::ORB_LIMIT_DEFAULT,
   parameter int DIST_TABLE_DEPTH = pzxod_pkg::DIST_DEPTH_DEFAULT
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   // left_reading [15:0], center_reading [31:16], right_reading [47:32]
   input  wire logic                               req_tvalid,
   output logic                                    req_tready,
   input  wire logic [pzxod_pkg::REQ_W-1:0]        req_tdata,
   // left_clean [15:0], center_clean [31:16], right_clean [47:32], activity [48],
   // position_valid [49], z_position [65:50], x_position [81:66], orb_hit [82],
   // orb_present [83], zero fill [87:84]
   output logic                                    rsp_tvalid,
   input  wire logic                               rsp_tready,
   output logic [pzxod_pkg::RSP_W-1:0]             rsp_tdata,
   input  wire logic                               csr_we,
   input  wire logic [pzxod_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [pzxod_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import pzxod_pkg::*;

   localparam int IDX_W = $clog2(DIST_TABLE_DEPTH + 1);
   localparam int SC_W  = IDX_W + 16;

   // sequencer
   state_type state_ff, state_in;

   // config registers
   logic [2:0]  mode_ff;
   logic [15:0] act_thr_ff, pos_min_ff, noise_l_ff, noise_c_ff, noise_r_ff;

   // per-word working registers
   logic [15:0]        l_ff, c_ff, r_ff;
   logic               act_ff, valid_ff, hit_ff, side_ff;
   logic [4:0]         e_ff;
   logic [15:0]        w_ff;
   logic [33:0]        acc_ff;
   logic [16:0]        g_ff;
   logic [15:0]        dl_ff, dr_ff;
   logic signed [22:0] p_ff;
   logic [44:0]        p2_ff;
   logic signed [47:0] num_ff;
   logic               neg_ff;
   logic [27:0]        n_ff;

   // persistent state
   logic signed [15:0] last_z_ff, last_x_ff;
   logic [2:0]         cnt_ff;
   logic               flag_ff;

   // output register
   logic               out_valid_ff;
   logic [RSP_W-1:0]   out_data_ff;

   // shared multiplier and tables
   logic signed [MUL_W-1:0]  mul_a, mul_b;
   logic signed [PROD_W-1:0] mul_prod;
   logic                     rom_en;
   logic [IDX_W-1:0]         rom_idx;
   logic [TBL_W-1:0]         t_lo, t_hi;
   logic [OCT_W-1:0]         scale;

   // input cleaning
   logic [15:0] in_l, in_c, in_r, cl_l, cl_c, cl_r;
   logic        in_range, accept, load_out;

   assign in_l = req_tdata[15:0];
   assign in_c = req_tdata[31:16];
   assign in_r = req_tdata[47:32];

   // saturating noise subtraction
   assign cl_l = !mode_ff[0] ? in_l : (noise_l_ff >= in_l ? '0 : in_l - noise_l_ff);
   assign cl_c = !mode_ff[0] ? in_c : (noise_c_ff >= in_c ? '0 : in_c - noise_c_ff);
   assign cl_r = !mode_ff[0] ? in_r : (noise_r_ff >= in_r ? '0 : in_r - noise_r_ff);
   assign in_range = (cl_l > pos_min_ff) && (cl_r > pos_min_ff);

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign load_out   = (state_ff == ST_DONE) && (!out_valid_ff || rsp_tready);

   // distance front end: octave and offset within octave
   logic [15:0] cur_v;
   logic [16:0] u_val;
   logic [4:0]  expo;
   logic [15:0] frac_u;

   assign cur_v = side_ff ? r_ff : l_ff;
   assign u_val = {1'b0, cur_v} + DIST_OFFSET;

   always_comb begin
      expo = '0;
      for (int k = 1; k < 17; k++) begin
         if (u_val[k]) begin
            expo = 5'(k);
         end
      end
   end

   assign frac_u = 16'(u_val - (17'd1 << expo));

   // table index and interpolation weight
   logic [SC_W-1:0]  scaled, shifted;
   logic [16:0]      pow_e, mask_e;
   logic [15:0]      w_cur;

   assign scaled  = mul_prod[SC_W-1:0];
   assign shifted = scaled >> e_ff;
   assign pow_e   = 17'd1 << e_ff;
   assign mask_e  = pow_e - 17'd1;
   assign w_cur   = scaled[15:0] & mask_e[15:0];
   assign rom_idx = (shifted >= SC_W'(DIST_TABLE_DEPTH)) ?
                    IDX_W'(DIST_TABLE_DEPTH - 1) : IDX_W'(shifted);

   // blended shape value and saturated distance
   logic [34:0] blend;
   logic [15:0] dist_q88;

   assign blend    = 35'(acc_ff) + 35'(mul_prod[33:0]);
   assign dist_q88 = (|mul_prod[PROD_W-1:40]) ? 16'hFFFF : mul_prod[39:24];

   // x and z back end
   logic signed [16:0] side_diff;
   logic [16:0]        side_sum;
   logic signed [47:0] z_diff, z_num;
   logic signed [47:0] z_mag;
   logic [19:0]        q0;
   logic [29:0]        q0x, rem;
   logic [20:0]        q_abs;
   logic signed [21:0] z_full;
   logic signed [15:0] z_new, x_new;
   logic signed [22:0] p_abs;
   logic [14:0]        x_abs;

   assign side_diff = $signed({1'b0, dl_ff}) - $signed({1'b0, dr_ff});
   assign side_sum  = {1'b0, dl_ff} + {1'b0, dr_ff};
   assign z_diff    = $signed(mul_prod[47:0]) - $signed({3'b000, p2_ff});
   // times 13 as shift and add
   assign z_num     = (z_diff <<< 3) + (z_diff <<< 2) + z_diff;
   assign z_mag     = num_ff[47] ? -num_ff : num_ff;

   // quotient estimate from the reciprocal, then one correction step
   assign q0    = mul_prod[57:38];
   assign q0x   = (30'(q0) << 10) + (30'(q0) << 7) + (30'(q0) << 6) +
                  (30'(q0) << 5) + (30'(q0) << 1);
   assign rem   = 30'(n_ff) - q0x;
   assign q_abs = 21'(q0) + ((rem >= Z_DIVISOR) ? 21'd1 : 21'd0);
   assign z_full = neg_ff ? -$signed({1'b0, q_abs}) : $signed({1'b0, q_abs});
   assign z_new = (z_full > 22'sd32767)  ? 16'sd32767 :
                  (z_full < -22'sd32768) ? -16'sd32768 : 16'(z_full);

   // x truncates toward zero
   assign p_abs = p_ff[22] ? -p_ff : p_ff;
   assign x_abs = p_abs[22:8];
   assign x_new = p_ff[22] ? -$signed({1'b0, x_abs}) : $signed({1'b0, x_abs});

   logic orb_in;
   assign orb_in = orb_test(last_z_ff, last_x_ff, c_ff, flag_ff);

   pzxod_mul u_mul (
      .clock   (clock),
      .op_a    (mul_a),
      .op_b    (mul_b),
      .prod_ff (mul_prod)
   );

   pzxod_dist_rom #(
      .DEPTH (DIST_TABLE_DEPTH)
   ) u_rom (
      .clock    (clock),
      .en       (rom_en),
      .idx      (rom_idx),
      .expo     (e_ff),
      .t_lo_ff  (t_lo),
      .t_hi_ff  (t_hi),
      .scale_ff (scale)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               state_in = (mode_ff[1] && in_range) ? ST_PREP : ST_DONE;
            end
         end
         ST_PREP:  state_in = ST_LOOK;
         ST_LOOK:  state_in = ST_WLO;
         ST_WLO:   state_in = ST_WHI;
         ST_WHI:   state_in = ST_GAIN;
         ST_GAIN:  state_in = ST_SCALE;
         ST_SCALE: state_in = ST_DIST;
         ST_DIST:  state_in = side_ff ? ST_XMUL : ST_PREP;
         ST_XMUL:  state_in = ST_XSQ;
         ST_XSQ:   state_in = ST_ZSUM;
         ST_ZSUM:  state_in = ST_ZNUM;
         ST_ZNUM:  state_in = ST_ZRCP;
         ST_ZRCP:  state_in = ST_ZFIN;
         ST_ZFIN:  state_in = mode_ff[2] ? ST_ORB : ST_DONE;
         ST_ORB:   state_in = ST_DONE;
         ST_DONE: begin
            if (!out_valid_ff || rsp_tready) begin
               state_in = ST_IDLE;
            end
         end
         default:  state_in = ST_IDLE;
      endcase
   end

   // multiplier operand select and table read enable
   always_comb begin
      mul_a  = '0;
      mul_b  = '0;
      rom_en = 1'b0;
      case (state_ff)
         ST_PREP: begin
            mul_a = MUL_W'(frac_u);
            mul_b = MUL_W'(DIST_TABLE_DEPTH);
         end
         ST_LOOK: begin
            rom_en = 1'b1;
         end
         ST_WLO: begin
            mul_a = MUL_W'(t_lo);
            mul_b = MUL_W'(pow_e - {1'b0, w_ff});
         end
         ST_WHI: begin
            mul_a = MUL_W'(t_hi);
            mul_b = MUL_W'(w_ff);
         end
         ST_SCALE: begin
            mul_a = MUL_W'(scale);
            mul_b = MUL_W'(g_ff);
         end
         ST_XMUL: begin
            mul_a = MUL_W'(side_diff);
            mul_b = X_GAIN;
         end
         ST_XSQ: begin
            mul_a = mul_prod[MUL_W-1:0];
            mul_b = mul_prod[MUL_W-1:0];
         end
         ST_ZSUM: begin
            mul_a = Z_GAIN;
            mul_b = MUL_W'(side_sum);
         end
         ST_ZRCP: begin
            mul_a = MUL_W'(z_mag[47:20]);
            mul_b = RECIP_1250;
         end
         default: begin
            mul_a = '0;
         end
      endcase
   end

   // config port
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= '0;
         act_thr_ff <= 16'd100;
         pos_min_ff <= 16'd22;
         noise_l_ff <= '0;
         noise_c_ff <= '0;
         noise_r_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_MODE:    mode_ff    <= csr_wdata[2:0];
            CSR_ACT_THR: act_thr_ff <= csr_wdata;
            CSR_POS_MIN: pos_min_ff <= csr_wdata;
            CSR_NOISE_L: noise_l_ff <= csr_wdata;
            CSR_NOISE_C: noise_c_ff <= csr_wdata;
            CSR_NOISE_R: noise_r_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // control and persistent state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
         last_z_ff    <= '0;
         last_x_ff    <= '0;
         cnt_ff       <= '0;
         flag_ff      <= 1'b0;
         side_ff      <= 1'b0;
         valid_ff     <= 1'b0;
         hit_ff       <= 1'b0;
      end else begin
         state_ff <= state_in;

         if (load_out) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end

         if (accept) begin
            side_ff  <= 1'b0;
            valid_ff <= 1'b0;
            hit_ff   <= 1'b0;
            // out of range drops the orb regardless of orb detection
            if (mode_ff[1] && !in_range) begin
               cnt_ff  <= '0;
               flag_ff <= 1'b0;
            end
         end

         if (state_ff == ST_DIST) begin
            side_ff <= 1'b1;
         end

         if (state_ff == ST_ZFIN) begin
            last_z_ff <= z_new;
            last_x_ff <= x_new;
            valid_ff  <= 1'b1;
         end

         // hysteresis counter
         if (state_ff == ST_ORB) begin
            hit_ff <= orb_in;
            if (orb_in) begin
               if (cnt_ff < 3'(ORB_COUNT_LIMIT)) begin
                  cnt_ff <= cnt_ff + 3'd1;
               end else begin
                  flag_ff <= 1'b1;
               end
            end else begin
               if (cnt_ff != '0) begin
                  cnt_ff <= cnt_ff - 3'd1;
               end else begin
                  flag_ff <= 1'b0;
               end
            end
         end
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (accept) begin
         l_ff   <= cl_l;
         c_ff   <= cl_c;
         r_ff   <= cl_r;
         act_ff <= (cl_l > act_thr_ff) || (cl_c > act_thr_ff) || (cl_r > act_thr_ff);
      end
      case (state_ff)
         ST_PREP: e_ff   <= expo;
         ST_LOOK: w_ff   <= w_cur;
         ST_WHI:  acc_ff <= mul_prod[33:0];
         ST_GAIN: g_ff   <= 17'(blend >> e_ff);
         ST_DIST: begin
            if (side_ff) begin
               dr_ff <= dist_q88;
            end else begin
               dl_ff <= dist_q88;
            end
         end
         ST_XSQ:  p_ff   <= mul_prod[22:0];
         ST_ZSUM: p2_ff  <= mul_prod[44:0];
         ST_ZNUM: num_ff <= z_num;
         ST_ZRCP: begin
            neg_ff <= num_ff[47];
            n_ff   <= z_mag[47:20];
         end
         default: begin
         end
      endcase
      if (load_out) begin
         out_data_ff <= {4'b0000, flag_ff, hit_ff, last_x_ff, last_z_ff,
                         valid_ff, act_ff, r_ff, c_ff, l_ff};
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

endmodule

`default_nettype wire

/* rtl/pzxod_checker.sv */
// port-level checks for the proximity zx position and orb detector
`default_nettype none

module pzxod_checker (
   input wire logic                               clock,
   input wire logic                               reset,
   input wire logic                               req_tvalid,
   input wire logic                               req_tready,
   input wire logic                               rsp_tvalid,
   input wire logic                               rsp_tready,
   input wire logic [pzxod_pkg::RSP_W-1:0]        rsp_tdata
);
   import pzxod_pkg::*;

   // stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result word changed while stalled");

   // nothing shown right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result word valid after reset");

   // one word at a time: busy after an accept
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("accepted a word back to back");

   // no orb hit without a fresh position
   a_hit_needs_pos: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[RSP_VALID_BIT] |-> !rsp_tdata[RSP_HIT_BIT])
      else $error("orb hit without position");

endmodule

bind proximity_zx_position_orb_detector_unit pzxod_checker u_checker (.*);

`default_nettype wire

/* tb/tb_proximity_zx_position_orb_detector_unit.sv */
// self-checking testbench for the proximity zx position and orb detector unit
`default_nettype none

module tb_proximity_zx_position_orb_detector_unit;
   import pzxod_pkg::*;

   localparam int ORB_LIMIT  = 4;
   localparam int TBL_DEPTH  = 256;
   // indexes past the six registers, writes there must be dropped
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_LO = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_HI = 3'd7;
   // mode bits
   localparam logic [2:0] MODE_NOISE = 3'b001;
   localparam logic [2:0] MODE_POS   = 3'b010;
   localparam logic [2:0] MODE_ORB   = 3'b100;
   localparam longint unsigned EXP_K = 64'd2583422829;

   typedef struct packed {
      logic [15:0] left_clean;
      logic [15:0] center_clean;
      logic [15:0] right_clean;
      logic        activity;
      logic        position_valid;
      logic [15:0] z_position;
      logic [15:0] x_position;
      logic        orb_hit;
      logic        orb_present;
   } sample_result_t;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [REQ_W-1:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RSP_W-1:0] rsp_tdata;
   logic csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   proximity_zx_position_orb_detector_unit #(
      .ORB_COUNT_LIMIT(ORB_LIMIT),
      .DIST_TABLE_DEPTH(TBL_DEPTH)
   ) dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always begin
      clock = 1'b1;
      #2;
      clock = 1'b0;
      #2;
   end

   // shadow configuration and detector state
   logic [2:0]  sh_mode;
   logic [15:0] sh_act_thr, sh_pos_min, sh_noise_l, sh_noise_c, sh_noise_r;
   int          orb_count;
   logic        orb_on;
   int          held_z, held_x;

   // power curve tables
   longint unsigned half_root [33];
   longint unsigned pow_frac [TBL_DEPTH + 1];
   longint unsigned octave_gain [17];

   logic [REQ_W-1:0] pending_words[$];
   sample_result_t   expected_results[$];
   int  errors = 0;
   bit  idle_on = 1'b1;
   bit  req_took = 1'b0;
   int  req_gap = 0;
   int  rsp_stall = 0;

   function automatic longint unsigned int_sqrt(longint unsigned a_in);
      longint unsigned a, res, b;
      a = a_in;
      res = 0;
      b = 64'h4000_0000_0000_0000;
      while (b > a) b = b >> 2;
      while (b != 0) begin
         if (a >= res + b) begin
            a = a - (res + b);
            res = (res >> 1) + b;
         end else begin
            res = res >> 1;
         end
         b = b >> 2;
      end
      return res;
   endfunction

   // 2^-y with y in q.32
   function automatic longint unsigned pow2_neg(longint unsigned y);
      logic [127:0] r;
      longint unsigned n;
      n = y >> 32;
      if (n >= 33) return 0;
      r = 128'h1_0000_0000;
      for (int j = 1; j <= 32; j++)
         if (y[32-j]) r = (r * 128'(half_root[j])) >> 32;
      return 64'(r >> n);
   endfunction

   // fractional log2 of a q1.31 mantissa
   function automatic longint unsigned frac_log2(longint unsigned m);
      logic [127:0] x;
      longint unsigned res;
      x = 128'(m);
      res = 0;
      for (int k = 1; k <= 32; k++) begin
         x = (x * x) >> 31;
         if (x >= 128'h1_0000_0000) begin
            x = x >> 1;
            res[32-k] = 1'b1;
         end
      end
      return res;
   endfunction

   task automatic build_curve();
      longint unsigned m, y;
      logic [127:0] t;
      half_root[0] = 0;
      half_root[1] = int_sqrt(64'h8000_0000_0000_0000);
      for (int i = 2; i <= 32; i++) half_root[i] = int_sqrt(half_root[i-1] << 32);
      for (int i = 0; i < TBL_DEPTH; i++) begin
         m = ((64'(TBL_DEPTH) + 64'(i)) << 31) / 64'(TBL_DEPTH);
         t = 128'(EXP_K) * 128'(frac_log2(m));
         y = 64'(t >> 32);
         pow_frac[i] = pow2_neg(y) >> 16;
      end
      pow_frac[TBL_DEPTH] = pow2_neg(EXP_K) >> 16;
      for (int i = 0; i <= 16; i++)
         octave_gain[i] = (64'd1200 * pow2_neg(EXP_K * 64'(i))) >> 16;
   endtask

   // reading to distance in q8.8
   function automatic longint distance_of(logic [15:0] v);
      longint unsigned u, e, scaled, idx, w, g, d;
      u = 64'(v) + 60;
      e = 0;
      while (e < 16 && (u >> (e + 1)) != 0) e++;
      scaled = (u - (64'd1 << e)) * TBL_DEPTH;
      idx = scaled >> e;
      if (idx >= TBL_DEPTH) idx = TBL_DEPTH - 1;
      w = scaled & ((64'd1 << e) - 1);
      g = (pow_frac[idx] * ((64'd1 << e) - w) + pow_frac[idx+1] * w) >> e;
      d = (octave_gain[e] * g) >> 24;
      return (d > 65535) ? 65535 : longint'(d);
   endfunction

   function automatic int sat16(longint v);
      if (v > 32767) return 32767;
      if (v < -32768) return -32768;
      return int'(v);
   endfunction

   function automatic logic [15:0] minus_floor(logic [15:0] a, logic [15:0] n);
      return (n >= a) ? 16'd0 : a - n;
   endfunction

   // leaving limits apply while the orb is on
   function automatic bit inside_orb(int z, int x, logic [15:0] c, bit leaving);
      int cx, czh, czl, sx, szh, szl, cmax;
      cx = leaving ? 95 : 80;    czh = leaving ? 870 : 850; czl = leaving ? 180 : 200;
      sx = leaving ? 480 : 440;  szh = leaving ? 770 : 750; szl = leaving ? 160 : 170;
      cmax = leaving ? 2700 : 2500;
      if (int'(c) >= cmax) return 1'b0;
      if (x < cx && x > -cx && z < czh && z > czl) return 1'b1;
      return x < sx && x > -sx && z < szh && z > szl;
   endfunction

   task automatic track_sample(input logic [REQ_W-1:0] w);
      sample_result_t res;
      logic [15:0] l, c, r;
      longint dl, dr, p, num;
      bit hit;
      l = w[15:0];
      c = w[31:16];
      r = w[47:32];
      hit = 1'b0;
      res = '0;
      if (sh_mode & MODE_NOISE) begin
         l = minus_floor(l, sh_noise_l);
         c = minus_floor(c, sh_noise_c);
         r = minus_floor(r, sh_noise_r);
      end
      res.activity = (l > sh_act_thr) || (c > sh_act_thr) || (r > sh_act_thr);
      if (sh_mode & MODE_POS) begin
         if (l > sh_pos_min && r > sh_pos_min) begin
            dl = distance_of(l);
            dr = distance_of(r);
            p = 50 * (dl - dr);
            num = 13 * (64'sd2560000 * (dl + dr) - p * p);
            held_x = sat16(p / 256);
            held_z = sat16(num / 64'sd1310720000);
            res.position_valid = 1'b1;
            if (sh_mode & MODE_ORB) begin
               hit = inside_orb(held_z, held_x, c, orb_on);
               if (hit) begin
                  if (orb_count < ORB_LIMIT) orb_count++;
                  else orb_on = 1'b1;
               end else begin
                  if (orb_count > 0) orb_count--;
                  else orb_on = 1'b0;
               end
            end
         end else begin
            // out of range drops the orb regardless of the orb enable
            orb_count = 0;
            orb_on = 1'b0;
         end
      end
      res.left_clean = l;
      res.center_clean = c;
      res.right_clean = r;
      res.z_position = 16'(held_z);
      res.x_position = 16'(held_x);
      res.orb_hit = hit;
      res.orb_present = orb_on;
      expected_results.push_back(res);
   endtask

   task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
      if (want !== got) begin
         errors++;
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      end
   endtask

   // monitor: both handshakes sampled at the rising edge
   always @(posedge clock) begin
      sample_result_t want;
      if (!reset) begin
         req_took = req_tvalid && req_tready;
         if (req_took) track_sample(req_tdata);
         if (rsp_tvalid && rsp_tready) begin
            if (expected_results.size() == 0) begin
               errors++;
               $display("%0t: unexpected result word, expected none, actual %h",
                        $time, rsp_tdata);
            end else begin
               want = expected_results.pop_front();
               check_field("left_clean", want.left_clean, rsp_tdata[15:0]);
               check_field("center_clean", want.center_clean, rsp_tdata[31:16]);
               check_field("right_clean", want.right_clean, rsp_tdata[47:32]);
               check_field("activity", want.activity, rsp_tdata[48]);
               check_field("position_valid", want.position_valid, rsp_tdata[49]);
               check_field("z_position", want.z_position, rsp_tdata[65:50]);
               check_field("x_position", want.x_position, rsp_tdata[81:66]);
               check_field("orb_hit", want.orb_hit, rsp_tdata[82]);
               check_field("orb_present", want.orb_present, rsp_tdata[83]);
               check_field("zero_fill", 16'd0, rsp_tdata[87:84]);
            end
         end
      end
   end

   // mostly no gap, some short, a few long
   function automatic int pick_gap();
      int roll;
      if (!idle_on) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 60) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // driver: one assignment per signal per falling edge
   always @(negedge clock) begin
      logic nxt_valid;
      logic [REQ_W-1:0] nxt_data;
      logic nxt_ready;
      if (!reset) begin
         nxt_valid = req_tvalid;
         nxt_data = req_tdata;
         if (req_tvalid && req_took) begin
            nxt_valid = 1'b0;
            req_gap = pick_gap();
         end
         if (!nxt_valid) begin
            if (req_gap > 0) begin
               req_gap--;
            end else if (pending_words.size() != 0) begin
               nxt_valid = 1'b1;
               nxt_data = pending_words.pop_front();
            end
         end
         req_tvalid <= nxt_valid;
         req_tdata <= nxt_data;
         // result side stalls
         if (rsp_stall > 0) begin
            rsp_stall--;
            nxt_ready = 1'b0;
         end else begin
            rsp_stall = pick_gap();
            nxt_ready = (rsp_stall == 0);
         end
         rsp_tready <= nxt_ready;
      end
   end

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [15:0] val);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      case (idx)
         CSR_MODE:    sh_mode = val[2:0];
         CSR_ACT_THR: sh_act_thr = val;
         CSR_POS_MIN: sh_pos_min = val;
         CSR_NOISE_L: sh_noise_l = val;
         CSR_NOISE_C: sh_noise_c = val;
         CSR_NOISE_R: sh_noise_r = val;
         default: ;
      endcase
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic load_config(input logic [15:0] mode, thr, pmin, nl, nc, nr);
      write_reg(CSR_MODE, mode);
      write_reg(CSR_ACT_THR, thr);
      write_reg(CSR_POS_MIN, pmin);
      write_reg(CSR_NOISE_L, nl);
      write_reg(CSR_NOISE_C, nc);
      write_reg(CSR_NOISE_R, nr);
   endtask

   function automatic logic [REQ_W-1:0] pack_sample(int l, int c, int r);
      return {16'(r), 16'(c), 16'(l)};
   endfunction

   // a run of samples near the orb zone, plus noise and dropouts
   task automatic queue_random(input int count);
      int kind, base, l, c, r;
      int run;
      run = 0;
      base = 300;
      for (int k = 0; k < count; k++) begin
         if (run == 0) begin
            run = $urandom_range(2, 14);
            base = $urandom_range(120, 1400);
         end
         run--;
         kind = $urandom_range(0, 99);
         if (kind < 60) begin
            l = base + $urandom_range(0, 80) - 40;
            r = base + $urandom_range(0, 80) - 40;
            c = ($urandom_range(0, 3) == 0) ? $urandom_range(2300, 2900)
                                            : $urandom_range(0, 2600);
         end else if (kind < 80) begin
            l = $urandom_range(0, 65535);
            c = $urandom_range(0, 65535);
            r = $urandom_range(0, 65535);
         end else begin
            l = $urandom_range(0, 40);
            c = $urandom_range(0, 300);
            r = $urandom_range(0, 4000);
            if ($urandom_range(0, 1)) begin
               c = l; l = r; r = c;
               c = $urandom_range(0, 300);
            end
         end
         pending_words.push_back(pack_sample(l, c, r));
      end
   endtask

   task automatic drain();
      while (pending_words.size() != 0 || req_tvalid || expected_results.size() != 0)
         @(posedge clock);
      // a word may still be in flight after the last check
      repeat (40) @(posedge clock);
   endtask

   initial begin
      sh_mode = '0;
      sh_act_thr = 16'd100;
      sh_pos_min = 16'd22;
      sh_noise_l = '0;
      sh_noise_c = '0;
      sh_noise_r = '0;
      orb_count = 0;
      orb_on = 1'b0;
      held_z = 0;
      held_x = 0;
      build_curve();
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset defaults with everything off
      pending_words.push_back(pack_sample(0, 0, 0));
      pending_words.push_back(pack_sample(65535, 65535, 65535));
      pending_words.push_back(pack_sample(101, 100, 100));
      drain();

      // all features on, directed corners and an orb approach
      load_config(16'd7, 16'd100, 16'd22, 16'd0, 16'd0, 16'd0);
      pending_words.push_back(pack_sample(22, 500, 500));
      pending_words.push_back(pack_sample(23, 500, 23));
      pending_words.push_back(pack_sample(65535, 0, 65535));
      pending_words.push_back(pack_sample(65535, 0, 23));
      pending_words.push_back(pack_sample(23, 0, 65535));
      for (int k = 0; k < 8; k++) pending_words.push_back(pack_sample(300, 1000, 300));
      pending_words.push_back(pack_sample(300, 2600, 300));
      pending_words.push_back(pack_sample(300, 2800, 300));
      for (int k = 0; k < 6; k++) pending_words.push_back(pack_sample(5000, 1000, 5000));
      pending_words.push_back(pack_sample(10, 0, 300));
      drain();

      // noise subtraction at its extremes, spare indexes ignored
      write_reg(CSR_SPARE_LO, 16'hFFFF);
      write_reg(CSR_SPARE_HI, 16'hFFFF);
      load_config(16'd1, 16'd0, 16'd0, 16'hFFFF, 16'd0, 16'd1);
      pending_words.push_back(pack_sample(65535, 1, 0));
      pending_words.push_back(pack_sample(1234, 0, 1));
      drain();

      idle_on = 1'b0;
      load_config(16'd7, 16'd100, 16'd22, 16'd0, 16'd0, 16'd0);
      queue_random(150);
      drain();

      idle_on = 1'b1;
      load_config(16'd7, 16'd65535, 16'd65535, 16'd0, 16'd0, 16'd0);
      queue_random(60);
      drain();

      load_config(16'd7, 16'd300, 16'd0, 16'd20, 16'd50, 16'd20);
      queue_random(150);
      drain();

      load_config(16'd6, 16'd1000, 16'd100, 16'd0, 16'd0, 16'd0);
      queue_random(120);
      drain();

      for (int ph = 0; ph < 4; ph++) begin
         idle_on = (ph != 2);
         load_config(16'($urandom_range(0, 7)), 16'($urandom_range(0, 65535)),
                     16'($urandom_range(0, 200)), 16'($urandom_range(0, 65535)),
                     16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
         if ($urandom_range(0, 1)) begin
            write_reg(CSR_NOISE_L, 16'($urandom_range(0, 60)));
            write_reg(CSR_NOISE_C, 16'($urandom_range(0, 300)));
            write_reg(CSR_NOISE_R, 16'($urandom_range(0, 60)));
         end
         queue_random(55);
         drain();
      end

      if (errors == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

   // watchdog
   initial begin
      #4000000;
      $display("RESULT: ERROR");
      $finish;
   end

endmodule

`default_nettype wire
